### sv/ddps_pkg.sv
`timescale 1ns / 1ps

package ddps_pkg;

    // Width of the internal time base; only the low TIME_W bits of now_time are used.
    localparam int TIME_W = 64;
    // Width of the interval registers.
    localparam int IV_W = 32;
    // Width of the divider step counter.
    localparam int CNT_W = $clog2(TIME_W);
    // Width of a deadline sum, wide enough to show a carry past the time base.
    localparam int SUM_W = ((TIME_W > IV_W) ? TIME_W : IV_W) + 1;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [IV_W-1:0]   iv_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SUM_W-1:0]  sum_t;

    // Register values after reset.
    localparam iv_t SAMPLE_IV_RST = iv_t'(1000);
    localparam iv_t POLL_IV_RST   = iv_t'(10000);

    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_CHECK    = 2'd1,
        MODE_COMPLETE = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BADCFG   = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        CFG_SAMPLE_INTERVAL = 1'b0,
        CFG_POLL_INTERVAL   = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PICK,
        S_DIV,
        S_ADD,
        S_COMMIT,
        S_OUT
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] now_time;
        logic        poll_attempted;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        poll_due;
        logic [63:0] sample_deadline_out;
        logic [63:0] poll_deadline_out;
    } out_item_t;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/ddps_div.sv
`timescale 1ns / 1ps

// Restoring divider that produces the remainder of a time value divided by
// an interval, one dividend bit per cycle.
module ddps_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ddps_pkg::time_t     dividend,
    input  ddps_pkg::iv_t       divisor,
    output ddps_pkg::div_stat_t stat,
    output ddps_pkg::iv_t       rem
);

    ddps_pkg::time_t dvd_reg;
    ddps_pkg::time_t dvd_next;
    ddps_pkg::iv_t   dsr_reg;
    ddps_pkg::iv_t   dsr_next;
    ddps_pkg::iv_t   rem_reg;
    ddps_pkg::iv_t   rem_next;
    ddps_pkg::cnt_t  cnt_reg;
    ddps_pkg::cnt_t  cnt_next;
    logic            busy_reg;
    logic            busy_next;
    logic            done_reg;
    logic            done_next;
    logic [ddps_pkg::IV_W:0] trial;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[ddps_pkg::TIME_W-1]};
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = ddps_pkg::cnt_t'(ddps_pkg::TIME_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = ddps_pkg::iv_t'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[ddps_pkg::IV_W-1:0];
            end
            dvd_next = dvd_reg << 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - ddps_pkg::cnt_t'(1);
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

### sv/dual_deadline_poll_scheduler_core.sv
`timescale 1ns / 1ps
// Start, check and no-op run the dispatch and output states. Completion also runs the
// pick, divide and add states for each deadline it moves, on the bit-serial divider
// shared by both deadlines; no new input is taken until the output register is written.
// A new input is taken while an earlier result still waits in the output register.
// Asynchronous active-low reset clears both deadlines and loads intervals 1000 and 10000.
module dual_deadline_poll_scheduler_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ddps_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ddps_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ddps_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]         cfg_data
);

    ddps_pkg::state_t    state_reg;
    ddps_pkg::state_t    state_next;
    ddps_pkg::mode_t     mode_reg;
    ddps_pkg::mode_t     mode_next;
    ddps_pkg::time_t     now_reg;
    ddps_pkg::time_t     now_next;
    logic                polled_reg;
    logic                polled_next;
    ddps_pkg::time_t     s_dl_reg;
    ddps_pkg::time_t     s_dl_next;
    ddps_pkg::time_t     p_dl_reg;
    ddps_pkg::time_t     p_dl_next;
    ddps_pkg::time_t     cand_s_reg;
    ddps_pkg::time_t     cand_s_next;
    ddps_pkg::time_t     cand_p_reg;
    ddps_pkg::time_t     cand_p_next;
    logic                tgt_reg;
    logic                tgt_next;
    ddps_pkg::time_t     base_reg;
    ddps_pkg::time_t     base_next;
    ddps_pkg::status_t   status_reg;
    ddps_pkg::status_t   status_next;
    logic                due_reg;
    logic                due_next;
    ddps_pkg::iv_t       siv_reg;
    ddps_pkg::iv_t       piv_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    ddps_pkg::out_item_t out_data_reg;
    ddps_pkg::out_item_t out_data_next;

    logic                cfg_ok;
    ddps_pkg::time_t     pick_dl;
    ddps_pkg::iv_t       pick_iv;
    ddps_pkg::sum_t      start_sum;
    ddps_pkg::sum_t      adv_sum;
    logic                div_start;
    ddps_pkg::time_t     div_dividend;
    ddps_pkg::div_stat_t div_stat;
    ddps_pkg::iv_t       div_rem;

    // Shared remainder unit.
    ddps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pick_iv),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    // Interval registers; the user writes only while the block is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siv_reg <= ddps_pkg::SAMPLE_IV_RST;
            piv_reg <= ddps_pkg::POLL_IV_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ddps_pkg::CFG_SAMPLE_INTERVAL: siv_reg <= cfg_data;
                ddps_pkg::CFG_POLL_INTERVAL:   piv_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign cfg_ok = (siv_reg != '0) && (piv_reg != '0) && (piv_reg >= siv_reg);

    // Deadline and interval of the grid being advanced.
    assign pick_dl = tgt_reg ? p_dl_reg : s_dl_reg;
    assign pick_iv = tgt_reg ? piv_reg : siv_reg;

    // Adders: start anchor, and the next grid point (now - remainder + interval).
    assign start_sum    = ddps_pkg::sum_t'(now_reg) + ddps_pkg::sum_t'(piv_reg);
    assign adv_sum      = ddps_pkg::sum_t'(base_reg) + ddps_pkg::sum_t'(pick_iv);
    assign div_dividend = now_reg - pick_dl;

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        polled_next    = polled_reg;
        s_dl_next      = s_dl_reg;
        p_dl_next      = p_dl_reg;
        cand_s_next    = cand_s_reg;
        cand_p_next    = cand_p_reg;
        tgt_next       = tgt_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        due_next       = due_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ddps_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = in_data.mode;
                    now_next    = ddps_pkg::time_t'(in_data.now_time);
                    polled_next = in_data.poll_attempted;
                    state_next  = ddps_pkg::S_DISPATCH;
                end
            end
            ddps_pkg::S_DISPATCH:
            begin
                status_next = ddps_pkg::STATUS_OK;
                due_next    = 1'b0;
                state_next  = ddps_pkg::S_OUT;
                case (mode_reg)
                    ddps_pkg::MODE_START:
                    begin
                        if (!cfg_ok)
                        begin
                            status_next = ddps_pkg::STATUS_BADCFG;
                        end
                        else if ((start_sum >> ddps_pkg::TIME_W) != '0)
                        begin
                            status_next = ddps_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            s_dl_next = now_reg;
                            p_dl_next = ddps_pkg::time_t'(start_sum);
                        end
                    end
                    ddps_pkg::MODE_CHECK:
                    begin
                        due_next = (now_reg >= p_dl_reg);
                    end
                    ddps_pkg::MODE_COMPLETE:
                    begin
                        if (!cfg_ok)
                        begin
                            status_next = ddps_pkg::STATUS_BADCFG;
                        end
                        else
                        begin
                            cand_s_next = s_dl_reg;
                            cand_p_next = p_dl_reg;
                            tgt_next    = 1'b0;
                            state_next  = ddps_pkg::S_PICK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ddps_pkg::S_PICK:
            begin
                // A deadline already in the future stays where it is.
                if (pick_dl > now_reg)
                begin
                    if (!tgt_reg && polled_reg)
                    begin
                        tgt_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ddps_pkg::S_COMMIT;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ddps_pkg::S_DIV;
                end
            end
            ddps_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    base_next  = now_reg - ddps_pkg::time_t'(div_rem);
                    state_next = ddps_pkg::S_ADD;
                end
            end
            ddps_pkg::S_ADD:
            begin
                if ((adv_sum >> ddps_pkg::TIME_W) != '0)
                begin
                    // Refuse the whole transaction; neither deadline moves.
                    status_next = ddps_pkg::STATUS_OVERFLOW;
                    state_next  = ddps_pkg::S_OUT;
                end
                else
                begin
                    if (tgt_reg)
                    begin
                        cand_p_next = ddps_pkg::time_t'(adv_sum);
                        state_next  = ddps_pkg::S_COMMIT;
                    end
                    else
                    begin
                        cand_s_next = ddps_pkg::time_t'(adv_sum);
                        if (polled_reg)
                        begin
                            tgt_next   = 1'b1;
                            state_next = ddps_pkg::S_PICK;
                        end
                        else
                        begin
                            state_next = ddps_pkg::S_COMMIT;
                        end
                    end
                end
            end
            ddps_pkg::S_COMMIT:
            begin
                s_dl_next  = cand_s_reg;
                p_dl_next  = cand_p_reg;
                state_next = ddps_pkg::S_OUT;
            end
            ddps_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next                    = 1'b1;
                    out_data_next.status              = status_reg;
                    out_data_next.poll_due            = due_reg;
                    out_data_next.sample_deadline_out = 64'(s_dl_reg);
                    out_data_next.poll_deadline_out   = 64'(p_dl_reg);
                    state_next                        = ddps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ddps_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and architectural deadlines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddps_pkg::S_IDLE;
            s_dl_reg      <= '0;
            p_dl_reg      <= '0;
            tgt_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_dl_reg      <= s_dl_next;
            p_dl_reg      <= p_dl_next;
            tgt_reg       <= tgt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        now_reg      <= now_next;
        polled_reg   <= polled_next;
        cand_s_reg   <= cand_s_next;
        cand_p_reg   <= cand_p_next;
        base_reg     <= base_next;
        status_reg   <= status_next;
        due_reg      <= due_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != ddps_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The divider only reports a result while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ddps_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    // A committed sample deadline always lies strictly after the completion time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddps_pkg::S_COMMIT) |-> (cand_s_reg > now_reg))
        else $error("sample deadline not advanced past completion time");

    // After a poll, the committed poll deadline lies strictly after the completion time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddps_pkg::S_COMMIT && polled_reg) |-> (cand_p_reg > now_reg))
        else $error("poll deadline not advanced past completion time");

endmodule

### sim/dual_deadline_poll_scheduler_core_tb.sv
`timescale 1ns / 1ps

module dual_deadline_poll_scheduler_core_tb;

    import ddps_pkg::*;

    localparam logic [63:0] TIME_MAX = {64{1'b1}} >> (64 - TIME_W);
    localparam int RUN_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 500;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 115;

    // One row of the directed stimulus: either a register write or a transaction.
    typedef struct {
        bit          is_cfg;
        cfg_idx_t    idx;
        logic [31:0] val;
        in_item_t    item;
        bit          given;
        out_item_t   exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_SAMPLE_INTERVAL;
    logic [31:0] cfg_data = '0;

    // Scheduler state as the testbench expects it to be.
    logic [31:0] sample_iv = 32'd1000;
    logic [31:0] poll_iv = 32'd10000;
    logic [63:0] sample_dl = '0;
    logic [63:0] poll_dl = '0;

    out_item_t   awaited_reports[$];
    bit          idle_on = 1'b1;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          settings_applied = 0;
    int          mode_seen[4] = '{0, 0, 0, 0};
    int          status_seen[4] = '{0, 0, 0, 0};

    dual_deadline_poll_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Moves a deadline to the first point of its grid strictly after now.
    // Returns 0 when that point lies past the end of the time base.
    function automatic bit next_grid_point(input logic [63:0] dl, input logic [31:0] iv,
                                           input logic [63:0] now,
                                           output logic [63:0] dl_next);
        logic [63:0] steps;
        logic [63:0] iv64;
        dl_next = dl;
        iv64 = {32'b0, iv};
        if (dl > now)
            return 1'b1;
        steps = (now - dl) / iv64;
        if (steps == TIME_MAX)
            return 1'b0;
        steps = steps + 64'd1;
        if (steps > (TIME_MAX - dl) / iv64)
            return 1'b0;
        dl_next = dl + steps * iv64;
        return 1'b1;
    endfunction

    // Computes the report for one transaction and updates the expected deadlines.
    function automatic out_item_t predict_deadlines(input in_item_t it);
        out_item_t   rep;
        logic [63:0] now;
        logic [63:0] s_next;
        logic [63:0] p_next;
        bit          cfg_good;
        bit          fits;
        now = it.now_time & TIME_MAX;
        cfg_good = (sample_iv != 0) && (poll_iv != 0) && (poll_iv >= sample_iv);
        rep.status = STATUS_OK;
        rep.poll_due = 1'b0;
        case (it.mode)
            MODE_START:
            begin
                if (!cfg_good)
                    rep.status = STATUS_BADCFG;
                else if ({32'b0, poll_iv} > TIME_MAX - now)
                    rep.status = STATUS_OVERFLOW;
                else
                begin
                    sample_dl = now;
                    poll_dl = now + {32'b0, poll_iv};
                end
            end
            MODE_CHECK:
            begin
                rep.poll_due = (now >= poll_dl);
            end
            MODE_COMPLETE:
            begin
                if (!cfg_good)
                    rep.status = STATUS_BADCFG;
                else
                begin
                    // Both deadlines move together or not at all.
                    p_next = poll_dl;
                    fits = next_grid_point(sample_dl, sample_iv, now, s_next);
                    if (fits && it.poll_attempted)
                        fits = next_grid_point(poll_dl, poll_iv, now, p_next);
                    if (fits)
                    begin
                        sample_dl = s_next;
                        poll_dl = p_next;
                    end
                    else
                        rep.status = STATUS_OVERFLOW;
                end
            end
            default:
            begin
            end
        endcase
        rep.sample_deadline_out = sample_dl;
        rep.poll_deadline_out = poll_dl;
        return rep;
    endfunction

    function automatic stim_row_t op_row(input mode_t m, input logic [63:0] now,
                                         input bit polled);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.idx = CFG_SAMPLE_INTERVAL;
        row.val = '0;
        row.item.mode = m;
        row.item.now_time = now;
        row.item.poll_attempted = polled;
        row.given = 1'b0;
        row.exp = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input mode_t m, input logic [63:0] now,
                                            input bit polled, input status_t st,
                                            input bit due, input logic [63:0] s,
                                            input logic [63:0] p);
        stim_row_t row;
        row = op_row(m, now, polled);
        row.given = 1'b1;
        row.exp.status = st;
        row.exp.poll_due = due;
        row.exp.sample_deadline_out = s;
        row.exp.poll_deadline_out = p;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input cfg_idx_t idx, input logic [31:0] val);
        stim_row_t row;
        row = op_row(MODE_NOP, '0, 1'b0);
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        return row;
    endfunction

    // Picks where a schedule is anchored: zero, low, anywhere, or close to the end.
    function automatic logic [63:0] pick_origin();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 64'($urandom_range(0, 100000));
            2: return rand64() & TIME_MAX;
            default: return TIME_MAX - rand64() % ({32'b0, poll_iv} * 64'd4 + 64'd1);
        endcase
    endfunction

    // Offers one transaction, waits until it is taken and records its report.
    task automatic offer_item(input in_item_t it, input bit given, input out_item_t typed);
        int        gap;
        bit        stalled;
        out_item_t want;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
        begin
            @(negedge clk);
            stalled = (in_stall !== 1'b0);
            @(posedge clk);
        end
        while (stalled);
        want = predict_deadlines(it);
        if (given)
            want = typed;
        awaited_reports.push_back(want);
        items_sent++;
        mode_seen[int'(it.mode)]++;
    endtask

    // Writes a register once every outstanding report has come back.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        bit ready_s;
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            ready_s = (cfg_ready === 1'b1);
            @(posedge clk);
        end
        while (!ready_s);
        cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_INTERVAL)
            sample_iv = val;
        else
            poll_iv = val;
    endtask

    // Compares one received report against the oldest expected one.
    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (!$isunknown(got.status))
            status_seen[int'(got.status)]++;
        if (awaited_reports.size() == 0)
        begin
            if (mismatches < 10)
                $display("[%0t] report with no transaction outstanding: status=%0d due=%0b",
                         $realtime, got.status, got.poll_due);
            mismatches++;
            return;
        end
        want = awaited_reports.pop_front();
        if (got.status !== want.status || got.poll_due !== want.poll_due ||
            got.sample_deadline_out !== want.sample_deadline_out ||
            got.poll_deadline_out !== want.poll_deadline_out)
        begin
            if (mismatches < 10)
            begin
                $display("[%0t] report %0d mismatch", $realtime, results_seen);
                $display("    expected status=%0d due=%0b sample=%h poll=%h",
                         want.status, want.poll_due, want.sample_deadline_out,
                         want.poll_deadline_out);
                $display("    actual   status=%0d due=%0b sample=%h poll=%h",
                         got.status, got.poll_due, got.sample_deadline_out,
                         got.poll_deadline_out);
            end
            mismatches++;
        end
    endtask

    // Random schedule: a start, then mostly checks and completions at advancing times.
    task automatic run_random_phase(input int n_items);
        logic [63:0] t;
        logic [63:0] step;
        logic [63:0] moved;
        in_item_t    it;
        int          roll;
        t = pick_origin();
        it.mode = MODE_START;
        it.now_time = t;
        it.poll_attempted = 1'($urandom_range(0, 1));
        offer_item(it, 1'b0, '0);
        for (int k = 1; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            it.poll_attempted = 1'($urandom_range(0, 1));
            if (roll < 6)
            begin
                // Re-anchor the schedule, half the time at a fresh origin.
                if ($urandom_range(0, 1) == 1)
                    t = pick_origin();
                it.mode = MODE_START;
                it.now_time = t;
            end
            else if (roll < 11)
            begin
                // Noise: any mode at any time, without moving the session clock.
                it.mode = mode_t'($urandom_range(0, 3));
                it.now_time = rand64();
            end
            else
            begin
                step = '0;
                case ($urandom_range(0, 5))
                    0: step = 64'($urandom_range(0, 3));
                    1: step = rand64() % ({32'b0, sample_iv} * 64'd2 + 64'd1);
                    2: step = rand64() % ({32'b0, poll_iv} * 64'd3 + 64'd1);
                    3: t = sample_dl - 64'($urandom_range(0, 1));
                    4: t = poll_dl - 64'd1 + 64'($urandom_range(0, 2));
                    default: step = rand64() >> $urandom_range(0, 63);
                endcase
                // Time saturates at the end of the time base.
                moved = t + step;
                t = (moved < t) ? TIME_MAX : moved;
                it.mode = (roll < 45) ? MODE_CHECK : MODE_COMPLETE;
                it.now_time = t;
            end
            offer_item(it, 1'b0, '0);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, and report checking.
    initial
    begin : result_sink
        int        burst_left;
        int        hold_left;
        bit        held;
        bit        took;
        bit        stall_next;
        out_item_t got;
        burst_left = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            took = (out_valid === 1'b1) && !out_stall;
            got = out_data;
            @(posedge clk);
            if (took)
                check_result(got);
            if (!held && results_seen == HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                stall_next = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 14) - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            out_stall <= stall_next;
        end
    end

    // Stimulus: directed table, then randomized register settings and schedules.
    initial
    begin : stimulus
        stim_row_t   plan[$];
        logic [31:0] s_iv;
        logic [31:0] p_iv;
        logic [31:0] swap;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: 1000 and 10000, both deadlines zero.
        plan.push_back(known_row(MODE_CHECK, 64'd0, 1'b0, STATUS_OK, 1'b1, 64'd0, 64'd0));
        plan.push_back(known_row(MODE_START, TIME_MAX, 1'b1, STATUS_OVERFLOW, 1'b0,
                                 64'd0, 64'd0));
        plan.push_back(known_row(MODE_START, 64'd0, 1'b0, STATUS_OK, 1'b0,
                                 64'd0, 64'd10000));
        plan.push_back(known_row(MODE_CHECK, 64'd9999, 1'b0, STATUS_OK, 1'b0,
                                 64'd0, 64'd10000));
        plan.push_back(known_row(MODE_CHECK, 64'd10000, 1'b1, STATUS_OK, 1'b1,
                                 64'd0, 64'd10000));
        plan.push_back(op_row(MODE_COMPLETE, 64'd0, 1'b0));
        plan.push_back(op_row(MODE_COMPLETE, 64'd25500, 1'b1));
        // Deadlines already in the future are kept.
        plan.push_back(op_row(MODE_COMPLETE, 64'd1000, 1'b1));
        plan.push_back(op_row(MODE_NOP, rand64(), 1'b1));
        plan.push_back(op_row(MODE_CHECK, TIME_MAX, 1'b0));
        plan.push_back(known_row(MODE_START, TIME_MAX - 64'd10000, 1'b0, STATUS_OK, 1'b0,
                                 TIME_MAX - 64'd10000, TIME_MAX));
        plan.push_back(op_row(MODE_COMPLETE, TIME_MAX, 1'b1));
        plan.push_back(op_row(MODE_COMPLETE, TIME_MAX - 64'd10000, 1'b0));
        // A zero sample interval makes the configuration invalid.
        plan.push_back(cfg_row(CFG_SAMPLE_INTERVAL, 32'd0));
        plan.push_back(op_row(MODE_START, 64'd5, 1'b0));
        plan.push_back(op_row(MODE_COMPLETE, 64'd5, 1'b1));
        plan.push_back(op_row(MODE_CHECK, 64'd0, 1'b1));
        // Poll interval below the sample interval is invalid as well.
        plan.push_back(cfg_row(CFG_SAMPLE_INTERVAL, 32'd20000));
        plan.push_back(op_row(MODE_COMPLETE, 64'd123456, 1'b1));
        // Unit intervals: the step count itself reaches the end of the time base.
        plan.push_back(cfg_row(CFG_SAMPLE_INTERVAL, 32'd1));
        plan.push_back(cfg_row(CFG_POLL_INTERVAL, 32'd1));
        plan.push_back(known_row(MODE_START, 64'd0, 1'b0, STATUS_OK, 1'b0, 64'd0, 64'd1));
        plan.push_back(known_row(MODE_COMPLETE, TIME_MAX, 1'b0, STATUS_OVERFLOW, 1'b0,
                                 64'd0, 64'd1));
        plan.push_back(op_row(MODE_COMPLETE, TIME_MAX - 64'd1, 1'b1));
        plan.push_back(cfg_row(CFG_POLL_INTERVAL, 32'd0));
        plan.push_back(op_row(MODE_START, 64'd0, 1'b1));
        // Largest intervals.
        plan.push_back(cfg_row(CFG_SAMPLE_INTERVAL, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_POLL_INTERVAL, 32'hFFFF_FFFF));
        plan.push_back(known_row(MODE_START, 64'd0, 1'b0, STATUS_OK, 1'b0,
                                 64'd0, 64'h0000_0000_FFFF_FFFF));
        plan.push_back(op_row(MODE_COMPLETE, 64'h0000_0000_FFFF_FFFF, 1'b1));
        plan.push_back(op_row(MODE_NOP, 64'd0, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                offer_item(plan[i].item, plan[i].given, plan[i].exp);
        end

        // Randomized part: one register setting per phase, extremes and invalid ones included.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0, 11:
                begin
                    s_iv = 32'd1000;
                    p_iv = 32'd10000;
                end
                1:
                begin
                    s_iv = 32'd1;
                    p_iv = 32'd1;
                end
                2:
                begin
                    s_iv = 32'd1;
                    p_iv = 32'hFFFF_FFFF;
                end
                3:
                begin
                    s_iv = 32'hFFFF_FFFF;
                    p_iv = 32'hFFFF_FFFF;
                end
                4:
                begin
                    s_iv = $urandom_range(1, 5000);
                    p_iv = s_iv * $urandom_range(1, 20);
                end
                5:
                begin
                    s_iv = $urandom;
                    p_iv = $urandom;
                    if (p_iv < s_iv)
                    begin
                        swap = s_iv;
                        s_iv = p_iv;
                        p_iv = swap;
                    end
                end
                6:
                begin
                    s_iv = 32'd0;
                    p_iv = $urandom;
                end
                7:
                begin
                    s_iv = $urandom_range(2, 100000);
                    p_iv = s_iv - 32'd1;
                end
                8:
                begin
                    s_iv = $urandom;
                    p_iv = 32'd0;
                end
                9:
                begin
                    s_iv = 32'd7;
                    p_iv = 32'd7;
                end
                default:
                begin
                    s_iv = $urandom_range(1, 50);
                    p_iv = $urandom_range(s_iv, 500);
                end
            endcase
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            write_reg(CFG_SAMPLE_INTERVAL, s_iv);
            write_reg(CFG_POLL_INTERVAL, p_iv);
            settings_applied++;
            run_random_phase(PHASE_ITEMS);
        end

        // Let every outstanding report come back, then a few quiet cycles.
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d transactions (start %0d, check %0d, complete %0d, no-op %0d)",
                 items_sent, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("over %0d register settings; reports checked: %0d (ok %0d, bad config %0d,",
                 settings_applied, results_seen, status_seen[0], status_seen[1]);
        $display("overflow %0d), mismatches %0d.", status_seen[2], mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### dual_deadline_poll_scheduler_core.f
sv/ddps_pkg.sv
sv/ddps_div.sv
sv/dual_deadline_poll_scheduler_core.sv
sim/dual_deadline_poll_scheduler_core_tb.sv
